// ===== design/assert_macros.svh =====
// Assertion macros shared by the bit timing search design.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, cond, msg)
`endif
`endif

// ===== design/cbts_pkg.sv =====
// Package for the CAN bit timing search: widths, constants, types and the segment split.
// Depends on nothing; imported by every module of the design.
package cbts_pkg;

   localparam int MAX_PRESCALER = 64;

   localparam int RATE_W      = 20;
   localparam int CLOCK_W     = 28;
   localparam int PRE_W       = $clog2(MAX_PRESCALER + 1);
   localparam int DSR_W       = PRE_W + RATE_W;
   localparam int CNT_W       = $clog2(CLOCK_W + 1);
   localparam int TQ_W        = 5;
   localparam int ERR_W       = 14;
   localparam int PRE_OUT_W   = 7;
   localparam int SEG1_W      = 5;
   localparam int SEG2_W      = 4;
   localparam int SJW_W       = 3;

   localparam int REQ_DATA_W    = ((RATE_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W  = PRE_OUT_W + SEG1_W + SEG2_W + SJW_W + ERR_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(24000000);

   localparam int TOL_DIV     = 100;
   localparam int TQ_MIN      = 3;
   localparam int TQ_MAX      = 25;
   localparam int SAMPLE_NUM  = 7;
   localparam int SAMPLE_RND  = 5;
   localparam int RECIP_TEN   = 205;
   localparam int RECIP_SHIFT = 11;
   localparam int SEG1_MAX    = 16;
   localparam int SEG2_MAX    = 8;
   localparam int SJW_MAX     = 4;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_ZERO_RATE = 2'd1,
      ST_NO_FIT    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      SRCH_IDLE,
      SRCH_TOL,
      SRCH_CAND,
      SRCH_TQ,
      SRCH_ACT,
      SRCH_WAIT_ACT,
      SRCH_EVAL,
      SRCH_NEXT
   } srch_state_type;

   typedef struct packed {
      logic               start;
      logic [CLOCK_W-1:0] dividend;
      logic [DSR_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [CLOCK_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      status_type           status;
      logic [PRE_OUT_W-1:0] prescaler;
      logic [SEG1_W-1:0]    seg_one;
      logic [SEG2_W-1:0]    seg_two;
      logic [SJW_W-1:0]     jump_width;
      logic [ERR_W-1:0]     rate_error;
   } srch_res_type;

   typedef struct packed {
      logic         idle;
      logic         valid;
      srch_res_type res;
   } srch_out_type;

   typedef struct packed {
      logic [SEG1_W-1:0] seg_one;
      logic [SEG2_W-1:0] seg_two;
   } seg_pair_type;

   // Splits a quanta count of 3 to 25 near a 70% sample point, then clamps both segments.
   function automatic seg_pair_type seg_split(input logic [TQ_W-1:0] tq);
      logic [7:0]   num;
      logic [18:0]  prod;
      logic [5:0]   s1_raw;
      logic [5:0]   s2_raw;
      seg_pair_type r;
      num    = 8'(tq) * 8'(SAMPLE_NUM) + 8'(SAMPLE_RND);
      prod   = 19'(num) * 19'(RECIP_TEN);
      s1_raw = 6'(prod >> RECIP_SHIFT) - 6'd1;
      s2_raw = 6'(tq) - 6'd1 - s1_raw;
      if (s1_raw == 6'd0) begin
         r.seg_one = SEG1_W'(1);
      end else if (s1_raw > 6'(SEG1_MAX)) begin
         r.seg_one = SEG1_W'(SEG1_MAX);
      end else begin
         r.seg_one = SEG1_W'(s1_raw);
      end
      if (s2_raw == 6'd0) begin
         r.seg_two = SEG2_W'(1);
      end else if (s2_raw > 6'(SEG2_MAX)) begin
         r.seg_two = SEG2_W'(SEG2_MAX);
      end else begin
         r.seg_two = SEG2_W'(s2_raw);
      end
      return r;
   endfunction

endpackage

// ===== design/cbts_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on cbts_pkg for widths and the request and response structs.
module cbts_div
   import cbts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CLOCK_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0]   rem_ff, rem_in;
   logic [DSR_W-1:0]   dsr_ff, dsr_in;
   logic [DSR_W:0]     trial;
   logic               fits;

   assign trial = {rem_ff, quo_ff[CLOCK_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(CLOCK_W);
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DSR_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[DSR_W-1:0];
         end
         quo_in = {quo_ff[CLOCK_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== design/cbts_search.sv =====
// Sequencer that walks the prescalers, drives the serial divider and keeps the best timing.
// Depends on cbts_pkg; talks to cbts_div through the divider request and response structs.
module cbts_search
   import cbts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RATE_W-1:0]  rate,
   input  logic [CLOCK_W-1:0] clock_hz,
   input  logic               take,
   input  div_rsp_type        div_rsp,
   output div_req_type        div_req,
   output srch_out_type       srch
);

   srch_state_type     state_ff, state_in;
   status_type         status_ff, status_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [ERR_W-1:0]   tol_ff, tol_in;
   logic [PRE_W-1:0]   pre_ff, pre_in;
   logic [SEG1_W-1:0]  s1_ff, s1_in;
   logic [SEG2_W-1:0]  s2_ff, s2_in;
   logic [CLOCK_W-1:0] err_ff, err_in;
   logic               have_ff, have_in;
   logic               done_ff, done_in;
   logic [PRE_W-1:0]   best_pre_ff, best_pre_in;
   logic [SEG1_W-1:0]  best_s1_ff, best_s1_in;
   logic [SEG2_W-1:0]  best_s2_ff, best_s2_in;
   logic [ERR_W-1:0]   min_err_ff, min_err_in;
   seg_pair_type       split;
   logic [CLOCK_W-1:0] rate_ext;
   logic               found;

   assign split    = seg_split(div_rsp.quotient[TQ_W-1:0]);
   assign rate_ext = CLOCK_W'(rate_ff);

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      rate_in     = rate_ff;
      tol_in      = tol_ff;
      pre_in      = pre_ff;
      s1_in       = s1_ff;
      s2_in       = s2_ff;
      err_in      = err_ff;
      have_in     = have_ff;
      done_in     = done_ff;
      best_pre_in = best_pre_ff;
      best_s1_in  = best_s1_ff;
      best_s2_in  = best_s2_ff;
      min_err_in  = min_err_ff;
      div_req.start    = 1'b0;
      div_req.dividend = clock_hz;
      div_req.divisor  = DSR_W'(pre_ff) * DSR_W'(rate_ff);
      unique case (state_ff)
         SRCH_IDLE: begin
            if (done_ff) begin
               if (take) begin
                  done_in = 1'b0;
               end
            end else if (start) begin
               rate_in = rate;
               have_in = 1'b0;
               if (rate == '0) begin
                  status_in = ST_ZERO_RATE;
                  done_in   = 1'b1;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = CLOCK_W'(rate);
                  div_req.divisor  = DSR_W'(TOL_DIV);
                  state_in         = SRCH_TOL;
               end
            end
         end
         SRCH_TOL: begin
            if (div_rsp.done) begin
               tol_in   = (div_rsp.quotient == '0) ? ERR_W'(1)
                                                   : div_rsp.quotient[ERR_W-1:0];
               pre_in   = PRE_W'(1);
               state_in = SRCH_CAND;
            end
         end
         SRCH_CAND: begin
            div_req.start = 1'b1;
            state_in      = SRCH_TQ;
         end
         SRCH_TQ: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient < CLOCK_W'(TQ_MIN) ||
                   div_rsp.quotient > CLOCK_W'(TQ_MAX)) begin
                  state_in = SRCH_NEXT;
               end else begin
                  s1_in    = split.seg_one;
                  s2_in    = split.seg_two;
                  state_in = SRCH_ACT;
               end
            end
         end
         SRCH_ACT: begin
            div_req.start   = 1'b1;
            div_req.divisor = DSR_W'(pre_ff) *
                              DSR_W'(TQ_W'(1) + TQ_W'(s1_ff) + TQ_W'(s2_ff));
            state_in        = SRCH_WAIT_ACT;
         end
         SRCH_WAIT_ACT: begin
            if (div_rsp.done) begin
               err_in   = (div_rsp.quotient >= rate_ext) ? div_rsp.quotient - rate_ext
                                                         : rate_ext - div_rsp.quotient;
               state_in = SRCH_EVAL;
            end
         end
         SRCH_EVAL: begin
            state_in = SRCH_NEXT;
            if (err_ff <= CLOCK_W'(tol_ff) &&
                (!have_ff || err_ff < CLOCK_W'(min_err_ff))) begin
               have_in     = 1'b1;
               best_pre_in = pre_ff;
               best_s1_in  = s1_ff;
               best_s2_in  = s2_ff;
               min_err_in  = err_ff[ERR_W-1:0];
               if (err_ff == '0) begin
                  status_in = ST_FOUND;
                  done_in   = 1'b1;
                  state_in  = SRCH_IDLE;
               end
            end
         end
         SRCH_NEXT: begin
            if (pre_ff == PRE_W'(MAX_PRESCALER)) begin
               status_in = have_ff ? ST_FOUND : ST_NO_FIT;
               done_in   = 1'b1;
               state_in  = SRCH_IDLE;
            end else begin
               pre_in   = pre_ff + PRE_W'(1);
               state_in = SRCH_CAND;
            end
         end
         default: begin
            state_in = SRCH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SRCH_IDLE;
         done_ff  <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         have_ff  <= have_in;
      end
      status_ff   <= status_in;
      rate_ff     <= rate_in;
      tol_ff      <= tol_in;
      pre_ff      <= pre_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      err_ff      <= err_in;
      best_pre_ff <= best_pre_in;
      best_s1_ff  <= best_s1_in;
      best_s2_ff  <= best_s2_in;
      min_err_ff  <= min_err_in;
   end

   assign found = status_ff == ST_FOUND;

   always_comb begin
      srch.idle           = state_ff == SRCH_IDLE && !done_ff;
      srch.valid          = done_ff;
      srch.res.status     = status_ff;
      srch.res.prescaler  = found ? PRE_OUT_W'(best_pre_ff) : '0;
      srch.res.seg_one    = found ? best_s1_ff : '0;
      srch.res.seg_two    = found ? best_s2_ff : '0;
      srch.res.jump_width = '0;
      if (found) begin
         srch.res.jump_width = (best_s2_ff > SEG2_W'(SJW_MAX)) ? SJW_W'(SJW_MAX)
                                                               : SJW_W'(best_s2_ff);
      end
      srch.res.rate_error = found ? min_err_ff : '0;
   end

endmodule

// ===== design/can_bit_timing_search.sv =====
// Each request runs the serial divider once for the tolerance, then twice per prescaler that
// is evaluated and once per prescaler that is skipped; a zero rate skips the divider. One
// request is searched at a time, and the next request is taken while the previous result
// waits in the output register.
// Reset is synchronous and active high; it sets clock_hz to 24 MHz and empties both sides.
`include "assert_macros.svh"

module can_bit_timing_search
   import cbts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // requested_rate
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // prescaler, seg_one, seg_two, jump_width, rate_error
   output logic [1:0]            rsp_tuser,  // status
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CLOCK_W-1:0]    csr_wdata
);

   logic [CLOCK_W-1:0] clock_hz_ff, clock_hz_in;
   logic               rsp_valid_ff, rsp_valid_in;
   srch_res_type       rsp_res_ff, rsp_res_in;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   srch_out_type       srch;
   logic               req_fire;
   logic               srch_take;

   assign csr_ready   = 1'b1;
   assign clock_hz_in = (csr_valid && csr_ready) ? csr_wdata : clock_hz_ff;

   assign req_tready = srch.idle;
   assign req_fire   = req_tvalid && req_tready;
   assign srch_take  = srch.valid && (!rsp_valid_ff || rsp_tready);

   cbts_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   cbts_search u_search (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .rate     (req_tdata[RATE_W-1:0]),
      .clock_hz (clock_hz_ff),
      .take     (srch_take),
      .div_rsp  (div_rsp),
      .div_req  (div_req),
      .srch     (srch)
   );

   assign rsp_valid_in = srch_take || (rsp_valid_ff && !rsp_tready);
   assign rsp_res_in   = srch_take ? srch.res : rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff  <= CLOCK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clock_hz_ff  <= clock_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_res_ff.rate_error, rsp_res_ff.jump_width,
                        rsp_res_ff.seg_two, rsp_res_ff.seg_one, rsp_res_ff.prescaler};

   `ASSERT_CLK(a_busy_after_req, clock, reset, req_fire |=> !srch.idle, "search not busy after request")
   `ASSERT_CLK(a_take_clears, clock, reset, srch_take |=> !srch.valid, "search result offered twice")
   `ASSERT_CLK(a_found_nonzero, clock, reset, (rsp_tvalid && rsp_res_ff.status == ST_FOUND) |-> (rsp_res_ff.prescaler != '0 && rsp_res_ff.seg_one != '0 && rsp_res_ff.seg_two != '0 && rsp_res_ff.jump_width != '0), "found timing has an empty field")
   `ASSERT_CLK(a_fail_empty, clock, reset, (rsp_tvalid && rsp_res_ff.status != ST_FOUND) |-> rsp_tdata == '0, "failed search carries timing data")

endmodule

// ===== test/tb_top.sv =====
// Testbench for can_bit_timing_search: directed and random bit rate requests under several
// controller clock settings, with a behavioral timing search that predicts every result.
// Depends on cbts_pkg and the can_bit_timing_search RTL.
`timescale 1ns / 100ps

module tb_top;
   import cbts_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int STALL_MAX      = 9;
   localparam int HOLD_CYCLES    = 12000;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int PHASE_ITEMS    = 16;
   localparam longint unsigned RATE_MAX  = (64'd1 << RATE_W) - 1;
   localparam longint unsigned CLOCK_MAX = (64'd1 << CLOCK_W) - 1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // requested_rate
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // prescaler, seg_one, seg_two, jump_width, rate_error
   logic [1:0]            rsp_tuser;        // status
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CLOCK_W-1:0]    csr_wdata = '0;

   longint unsigned clock_hz_model = CLOCK_RESET;
   srch_res_type    timing_q[$];
   int              mismatches = 0;
   bit              req_idle_on = 1'b1;
   bit              rsp_idle_on = 1'b1;
   logic            hold_req = 1'b0;
   int              hold_left = 0;
   int              stall_left = 0;
   int              quiet_cycles = 0;
   int unsigned     can_rates [9] = '{10000, 20000, 50000, 100000, 125000,
                                      250000, 500000, 800000, 1000000};

   can_bit_timing_search u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic srch_res_type predict_timing(input longint unsigned clk_hz,
                                                   input longint unsigned rate);
      longint unsigned tol;
      longint unsigned tq;
      longint unsigned s1;
      longint unsigned s2;
      longint unsigned act;
      longint unsigned err;
      longint unsigned min_err;
      longint unsigned best_s1;
      longint unsigned best_s2;
      int              best_pre;
      bit              found;
      srch_res_type    r;
      r        = '0;
      found    = 1'b0;
      min_err  = 0;
      best_s1  = 0;
      best_s2  = 0;
      best_pre = 0;
      if (rate == 0) begin
         r.status = ST_ZERO_RATE;
         return r;
      end
      tol = rate / 100;
      if (tol == 0) begin
         tol = 1;
      end
      for (int pre = 1; pre <= MAX_PRESCALER; pre++) begin
         tq = clk_hz / (longint'(pre) * rate);
         if (tq < 3 || tq > 25) begin
            continue;
         end
         s1 = (tq * 7 + 5) / 10 - 1;
         s2 = tq - 1 - s1;
         if (s1 < 1) s1 = 1;
         if (s1 > 16) s1 = 16;
         if (s2 < 1) s2 = 1;
         if (s2 > 8) s2 = 8;
         act = clk_hz / (longint'(pre) * (1 + s1 + s2));
         err = (act > rate) ? act - rate : rate - act;
         if (err > tol) begin
            continue;
         end
         if (!found || err < min_err) begin
            found    = 1'b1;
            min_err  = err;
            best_pre = pre;
            best_s1  = s1;
            best_s2  = s2;
            if (err == 0) begin
               break;
            end
         end
      end
      if (!found) begin
         r.status = ST_NO_FIT;
         return r;
      end
      r.status     = ST_FOUND;
      r.prescaler  = PRE_OUT_W'(best_pre);
      r.seg_one    = SEG1_W'(best_s1);
      r.seg_two    = SEG2_W'(best_s2);
      r.jump_width = SJW_W'((best_s2 > 4) ? 4 : best_s2);
      r.rate_error = ERR_W'(min_err);
      return r;
   endfunction

   // Most rates are aimed close to a real quanta split so that the search finds a fit.
   function automatic longint unsigned pick_rate(input longint unsigned clk_hz);
      int unsigned     pick;
      int unsigned     pre;
      int unsigned     tq;
      longint unsigned r;
      longint unsigned j;
      pick = $urandom_range(0, 99);
      if (pick < 60 && clk_hz >= 3) begin
         pre = $urandom_range(1, MAX_PRESCALER);
         tq  = $urandom_range(3, 25);
         r   = clk_hz / (pre * tq);
         if (r == 0) begin
            r = 1;
         end
         j = r / 150;
         r = r - j + $urandom_range(0, 32'(2 * j));
         if (r > RATE_MAX) begin
            r = RATE_MAX - $urandom_range(0, 4095);
         end
      end else if (pick < 80) begin
         r = can_rates[$urandom_range(0, 8)];
      end else if (pick < 95) begin
         r = $urandom_range(1, 32'(RATE_MAX));
      end else begin
         r = $urandom_range(0, 200);
      end
      return r;
   endfunction

   task automatic send_rate(input longint unsigned rate);
      int gap;
      gap = req_idle_on ? $urandom_range(0, STALL_MAX) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(rate[RATE_W-1:0]);
      do @(posedge clock); while (!req_tready);
      timing_q.push_back(predict_timing(clock_hz_model, rate));
   endtask

   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (timing_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_clock(input longint unsigned value);
      wait_drained();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= CLOCK_W'(value);
      do @(posedge clock); while (!csr_ready);
      clock_hz_model = value;
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_clock;
      int unsigned rates [14];
      rates = '{1000000, 500000, 250000, 125000, 100000, 50000, 20000,
                10000, 0, 1, 99, 1048575, 333333, 1000001};
      foreach (rates[i]) begin
         send_rate(rates[i]);
      end
   endtask

   task automatic test_clock_extremes;
      write_clock(0);
      send_rate(500000);
      send_rate(1);
      write_clock(CLOCK_MAX);
      send_rate(RATE_MAX);
      send_rate(1000000);
      send_rate(5000);
      write_clock(1);
      send_rate(1);
      send_rate(0);
   endtask

   // The receiver holds off while the sender keeps offering, so the input side must stall.
   task automatic test_backpressure;
      write_clock(24000000);
      hold_req    <= 1'b1;
      req_idle_on = 1'b0;
      repeat (8) send_rate(pick_rate(clock_hz_model));
      req_idle_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_random;
      longint unsigned clocks [7];
      int unsigned     mode;
      clocks = '{24000000, 16000000, 8000000, 80000000, 200000000,
                 $urandom_range(1000000, 200000000), 40000000};
      foreach (clocks[i]) begin
         write_clock(clocks[i]);
         mode = $urandom_range(0, 3);
         req_idle_on = (mode == 0) ? 1'b0 : 1'(mode[0]);
         rsp_idle_on = (mode == 0) ? 1'b0 : 1'(mode != 1 || mode[0]);
         repeat (PHASE_ITEMS) send_rate(pick_rate(clock_hz_model));
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      srch_res_type want;
      srch_res_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status     = status_type'(rsp_tuser);
            got.prescaler  = rsp_tdata[PRE_OUT_W-1:0];
            got.seg_one    = rsp_tdata[PRE_OUT_W +: SEG1_W];
            got.seg_two    = rsp_tdata[PRE_OUT_W + SEG1_W +: SEG2_W];
            got.jump_width = rsp_tdata[PRE_OUT_W + SEG1_W + SEG2_W +: SJW_W];
            got.rate_error = rsp_tdata[PRE_OUT_W + SEG1_W + SEG2_W + SJW_W +: ERR_W];
            if (timing_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result transfer with no request pending", $realtime);
               end
            end else begin
               want = timing_q.pop_front();
               if (got.status !== want.status || got.prescaler !== want.prescaler ||
                   got.seg_one !== want.seg_one || got.seg_two !== want.seg_two ||
                   got.jump_width !== want.jump_width ||
                   got.rate_error !== want.rate_error) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: expected st=%0d pre=%0d s1=%0d s2=%0d sjw=%0d err=%0d",
                              $realtime, want.status, want.prescaler, want.seg_one,
                              want.seg_two, want.jump_width, want.rate_error);
                     $display("%0t:   actual st=%0d pre=%0d s1=%0d s2=%0d sjw=%0d err=%0d",
                              $realtime, rsp_tuser, got.prescaler, got.seg_one,
                              got.seg_two, got.jump_width, got.rate_error);
                  end
               end
            end
            stall_left = rsp_idle_on ? $urandom_range(0, STALL_MAX) : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            hold_left = HOLD_CYCLES - 1;
            hold_req   <= 1'b0;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL can_bit_timing_search");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_clock();
      test_clock_extremes();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && timing_q.size() == 0) begin
         $display("PASS can_bit_timing_search");
      end else begin
         $display("FAIL can_bit_timing_search");
      end
      $finish;
   end

endmodule
